// File: src/glyph_coverage_pixel_blender_macros.svh
// assertion macros shared by the glyph coverage pixel blender rtl
// no dependencies; included inside module bodies
`ifndef GLYPH_COVERAGE_PIXEL_BLENDER_MACROS_SVH
`define GLYPH_COVERAGE_PIXEL_BLENDER_MACROS_SVH

// check that holds only out of reset
`define GCPB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds while reset is applied
`define GCPB_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/gcpb_pkg.sv
// shared types, register indexes and the coverage weight table
// no dependencies
`default_nettype none

package gcpb_pkg;

  typedef logic [31:0] pix_t;
  typedef logic [8:0]  weight_t;
  typedef logic [2:0]  cfg_idx_t;

  typedef struct packed {
    pix_t hi;
    pix_t lo;
  } pixel_pair_t;

  localparam cfg_idx_t REG_COLOR_ZERO   = 3'd0;
  localparam cfg_idx_t REG_COLOR_ONE    = 3'd1;
  localparam cfg_idx_t REG_COLOR_TWO    = 3'd2;
  localparam cfg_idx_t REG_COLOR_THREE  = 3'd3;
  localparam cfg_idx_t REG_COLOR_SELECT = 3'd4;
  localparam cfg_idx_t REG_BLEND_MODE   = 3'd5;

  localparam weight_t WEIGHT_ZERO = 9'h000;
  localparam weight_t WEIGHT_FULL = 9'h100;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  function automatic weight_t weight_of(input logic [3:0] nib);
    weight_t w;
    case (nib)
      4'h0: w = 9'h000;
      4'h1: w = 9'h011;
      4'h2: w = 9'h022;
      4'h3: w = 9'h033;
      4'h4: w = 9'h044;
      4'h5: w = 9'h055;
      4'h6: w = 9'h066;
      4'h7: w = 9'h077;
      4'h8: w = 9'h089;
      4'h9: w = 9'h09A;
      4'hA: w = 9'h0AB;
      4'hB: w = 9'h0BC;
      4'hC: w = 9'h0CD;
      4'hD: w = 9'h0DE;
      4'hE: w = 9'h0EF;
      4'hF: w = 9'h100;
      default: w = 9'h000;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: src/gcpb_lane.sv
// one blend lane: coverage nibble to weight, per-channel mix of fg over bg
// depends on gcpb_pkg
`default_nettype none

module gcpb_lane (
  input  logic [3:0]    coverage,
  input  gcpb_pkg::pix_t fg,
  input  gcpb_pkg::pix_t bg,
  output gcpb_pkg::pix_t pixel
);
  import gcpb_pkg::*;

  weight_t    weight;
  weight_t    inv;
  logic [17:0] acc [3];
  pix_t       mixed;

  assign weight = weight_of(coverage);
  assign inv    = WEIGHT_FULL - weight;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = 18'(fg[8*i +: 8]) * 18'(weight) + 18'(bg[8*i +: 8]) * 18'(inv);
    end
    mixed = {ALPHA_OPAQUE, acc[2][15:8], acc[1][15:8], acc[0][15:8]};
  end

  always_comb begin
    if (weight == WEIGHT_ZERO) begin
      pixel = bg;
    end else if (weight == WEIGHT_FULL) begin
      pixel = fg;
    end else begin
      pixel = mixed;
    end
  end

endmodule

`default_nettype wire

// File: src/gcpb_out_stage.sv
// merge stage: joins both lane pixels into one registered output request
// depends on gcpb_pkg and the assertion macro header
`default_nettype none

module gcpb_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gcpb_pkg::pix_t        lane_lo,
  input  gcpb_pkg::pix_t        lane_hi,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gcpb_pkg::pixel_pair_t out_pair
);
  import gcpb_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  pixel_pair_t pair_r;
  logic        in_fire;
  logic        out_fire;

  assign in_ready  = !valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = valid_r && out_ready;
  assign out_valid = valid_r;
  assign out_pair  = pair_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (out_fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pair_r <= '{hi: lane_hi, lo: lane_lo};
    end
  end

  `include "glyph_coverage_pixel_blender_macros.svh"

  `GCPB_ASSERT(a_fill_after_accept, clk, rst_n, in_fire |=> valid_r, "accepted request not held")
  `GCPB_ASSERT(a_drain_empties, clk, rst_n, (out_fire && !in_fire) |=> !valid_r, "drained stage still valid")
  `GCPB_ASSERT(a_stall_holds, clk, rst_n, (valid_r && !out_ready) |=> (valid_r && $stable(pair_r)), "stalled result changed")
  `GCPB_ASSERT_RST(a_reset_clears, clk, !rst_n |=> !valid_r, "valid set after reset")

endmodule

`default_nettype wire

// File: src/glyph_coverage_pixel_blender.sv
// glyph coverage pixel blender top: config registers, two blend lanes, output stage
// depends on gcpb_pkg, gcpb_lane, gcpb_out_stage
//
// usage:
//   in_* carries one request per cycle while in_tready is high: a coverage
//   byte (two 4-bit coverage values, low nibble first) and the two destination argb8888 pixels.
//   out_* returns the two new pixels for each request, in order, one result
//   per request.
//   cfg_* writes the four palette colors, the color select and the blend
//   mode; write only while no request is in flight.
// timing: a result is offered on out_* in the cycle after its request is taken.
// throughput: one request per cycle while in_tready is high; both pixels are
//   mixed at once by two parallel lanes, each with its own channel multipliers,
//   so the output register is the only sequential element on the data path.
// reset: rst_n low clears the palette, select and mode to zero and empties
//   the output register.
// stall: while out_tready is low the result holds; in_tready stays high as
//   long as the output register is empty or is being drained that cycle.
`default_nettype none

module glyph_coverage_pixel_blender (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // coverage_byte[7:0], dest_pixel_lo[39:8], dest_pixel_hi[71:40]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // out_pixel_lo[31:0], out_pixel_hi[63:32]
  input  logic        cfg_wr_en,
  input  gcpb_pkg::cfg_idx_t cfg_index,
  input  logic [31:0] cfg_wdata
);
  import gcpb_pkg::*;

  pix_t        palette_r [4];
  logic [1:0]  color_select_r;
  logic        blend_mode_r;

  logic [7:0]  coverage_byte;
  pix_t        dest_pixel_lo;
  pix_t        dest_pixel_hi;
  pix_t        fg;
  pix_t        bg_lo;
  pix_t        bg_hi;
  pix_t        lane_lo;
  pix_t        lane_hi;
  pixel_pair_t out_pair;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        palette_r[i] <= '0;
      end
      color_select_r <= '0;
      blend_mode_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_COLOR_ZERO:   palette_r[0]   <= cfg_wdata;
        REG_COLOR_ONE:    palette_r[1]   <= cfg_wdata;
        REG_COLOR_TWO:    palette_r[2]   <= cfg_wdata;
        REG_COLOR_THREE:  palette_r[3]   <= cfg_wdata;
        REG_COLOR_SELECT: color_select_r <= cfg_wdata[1:0];
        REG_BLEND_MODE:   blend_mode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign coverage_byte = in_tdata[7:0];
  assign dest_pixel_lo = in_tdata[39:8];
  assign dest_pixel_hi = in_tdata[71:40];

  assign fg    = palette_r[color_select_r];
  // solid mode mixes against black
  assign bg_lo = blend_mode_r ? dest_pixel_lo : '0;
  assign bg_hi = blend_mode_r ? dest_pixel_hi : '0;

  gcpb_lane u_lane_lo (
    .coverage (coverage_byte[3:0]),
    .fg       (fg),
    .bg       (bg_lo),
    .pixel    (lane_lo)
  );

  gcpb_lane u_lane_hi (
    .coverage (coverage_byte[7:4]),
    .fg       (fg),
    .bg       (bg_hi),
    .pixel    (lane_hi)
  );

  gcpb_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .lane_lo   (lane_lo),
    .lane_hi   (lane_hi),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pair  (out_pair)
  );

  assign out_tdata = {out_pair.hi, out_pair.lo};

endmodule

`default_nettype wire

// File: bench/glyph_coverage_pixel_blender_tb.sv
// self-checking bench for the glyph coverage pixel blender: directed probes, then random requests
// shadows palette, select and mode to predict both blended pixels; depends on gcpb_pkg and the rtl
`default_nettype none

module glyph_coverage_pixel_blender_tb;
  import gcpb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RESET_CYCLES = 12;
  localparam int BLOCK_COUNT = 10;
  localparam int BLOCK_ITEMS = 125;
  localparam int RESET_ROWS = 2;

  localparam cfg_idx_t REG_SPARE_LO = 3'd6;
  localparam cfg_idx_t REG_SPARE_HI = 3'd7;
  localparam logic MODE_SOLID = 1'b0;
  localparam logic MODE_BLEND = 1'b1;

  localparam pix_t RB_MASK = 32'h00FF00FF;
  localparam pix_t G_MASK = 32'h0000FF00;
  localparam pix_t OPAQUE = 32'hFF000000;
  localparam pix_t WHITE = 32'hFFFFFFFF;

  typedef struct {
    bit          known;
    pixel_pair_t pair;
  } claim_t;

  typedef struct {
    logic [1:0] sel;
    logic       mode;
    logic [7:0] cov;
    pix_t       dlo;
    pix_t       dhi;
    bit         known;
    pix_t       want_lo;
    pix_t       want_hi;
  } probe_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;  // coverage_byte[7:0], dest_pixel_lo[39:8], dest_pixel_hi[71:40]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;      // out_pixel_lo[31:0], out_pixel_hi[63:32]
  logic        cfg_wr_en = 1'b0;
  cfg_idx_t    cfg_index = REG_COLOR_ZERO;
  logic [31:0] cfg_wdata = '0;

  pix_t        palette_shadow [4];
  logic [1:0]  select_shadow = '0;
  logic        mode_shadow = MODE_SOLID;

  claim_t      request_claims [$];
  pixel_pair_t pending_pixels [$];
  probe_row_t  probe_rows [$];

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;

  glyph_coverage_pixel_blender i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // nibble n weighs n*17, plus one from 8 up, and 15 is full weight
  function automatic pix_t blend_pixel(pix_t fg, pix_t bg, logic [3:0] nib);
    logic [8:0]  w;
    logic [63:0] rb;
    logic [63:0] g;
    w = (nib == 4'hF) ? 9'h100 : 9'(nib) * 9'd17 + (nib[3] ? 9'd1 : 9'd0);
    if (w == 9'h000) return bg;
    if (w == 9'h100) return fg;
    rb = (64'(fg & RB_MASK) * w + 64'(bg & RB_MASK) * (9'h100 - w)) >> 8;
    g = (64'(fg & G_MASK) * w + 64'(bg & G_MASK) * (9'h100 - w)) >> 8;
    return OPAQUE | (g[31:0] & G_MASK) | (rb[31:0] & RB_MASK);
  endfunction

  function automatic pixel_pair_t blended_pair(logic [71:0] req);
    pixel_pair_t p;
    pix_t        fg;
    fg = palette_shadow[select_shadow];
    p.lo = blend_pixel(fg, (mode_shadow == MODE_BLEND) ? req[39:8] : '0, req[3:0]);
    p.hi = blend_pixel(fg, (mode_shadow == MODE_BLEND) ? req[71:40] : '0, req[7:4]);
    return p;
  endfunction

  always @(posedge clk) begin
    if (rst_n && cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result check, expectation capture and register shadow
  always @(posedge clk) begin
    pixel_pair_t want;
    claim_t      c;
    if (!rst_n) begin
      palette_shadow <= '{default: '0};
      select_shadow <= '0;
      mode_shadow <= MODE_SOLID;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_pixels.size() == 0) begin
          $error("result with no request pending: %h", out_tdata);
          fail_count++;
        end else begin
          want = pending_pixels.pop_front();
          if (out_tdata[31:0] !== want.lo) begin
            $error("out_pixel_lo expected %h actual %h", want.lo, out_tdata[31:0]);
            fail_count++;
          end
          if (out_tdata[63:32] !== want.hi) begin
            $error("out_pixel_hi expected %h actual %h", want.hi, out_tdata[63:32]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        c = request_claims.pop_front();
        pending_pixels.push_back(c.known ? c.pair : blended_pair(in_tdata));
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_COLOR_ZERO, REG_COLOR_ONE, REG_COLOR_TWO, REG_COLOR_THREE:
            palette_shadow[cfg_index[1:0]] <= cfg_wdata;
          REG_COLOR_SELECT: select_shadow <= cfg_wdata[1:0];
          REG_BLEND_MODE:   mode_shadow <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  task automatic send_request(logic [7:0] cov, pix_t dlo, pix_t dhi, bit known,
                              pixel_pair_t want);
    cfg_wr_en <= 1'b0;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    request_claims.push_back('{known, want});
    in_tvalid <= 1'b1;
    in_tdata <= {dhi, dlo, cov};
    do @(posedge clk); while (!in_tready);
  endtask

  // hold the sender until every pending result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    cfg_wr_en <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  initial begin
    probe_row_t  row;
    pixel_pair_t want;
    pix_t        dlo;
    pix_t        dhi;
    logic [1:0]  cur_sel;
    logic        cur_mode;
    logic [7:0]  cov;

    // after reset, then palette extremes, every nibble value and both modes
    probe_rows.push_back('{2'd0, MODE_SOLID, 8'hF0, WHITE, WHITE, 1'b1, 32'h0, 32'h0});
    probe_rows.push_back('{2'd0, MODE_SOLID, 8'h8F, WHITE, WHITE, 1'b1, 32'h0, OPAQUE});
    probe_rows.push_back('{2'd0, MODE_BLEND, 8'hF0, 32'h01234567, 32'hDEADBEEF, 1'b1,
                           32'h01234567, WHITE});
    probe_rows.push_back('{2'd0, MODE_SOLID, 8'h00, WHITE, WHITE, 1'b1, 32'h0, 32'h0});
    probe_rows.push_back('{2'd3, MODE_SOLID, 8'hFF, WHITE, 32'h0, 1'b1,
                           32'h80FF00FF, 32'h80FF00FF});
    probe_rows.push_back('{2'd1, MODE_BLEND, 8'hFF, WHITE, WHITE, 1'b1, 32'h0, 32'h0});
    probe_rows.push_back('{2'd2, MODE_BLEND, 8'h10, 32'h11223344, 32'h55667788, 1'b0, 0, 0});
    probe_rows.push_back('{2'd2, MODE_BLEND, 8'h32, 32'h99AABBCC, 32'hDDEEFF00, 1'b0, 0, 0});
    probe_rows.push_back('{2'd3, MODE_BLEND, 8'h54, 32'h0F0F0F0F, 32'hF0F0F0F0, 1'b0, 0, 0});
    probe_rows.push_back('{2'd0, MODE_BLEND, 8'h76, 32'h0, 32'h0, 1'b0, 0, 0});
    probe_rows.push_back('{2'd1, MODE_BLEND, 8'h98, WHITE, WHITE, 1'b0, 0, 0});
    probe_rows.push_back('{2'd2, MODE_SOLID, 8'hBA, WHITE, WHITE, 1'b0, 0, 0});
    probe_rows.push_back('{2'd3, MODE_SOLID, 8'hDC, 32'h0, WHITE, 1'b0, 0, 0});
    probe_rows.push_back('{2'd0, MODE_SOLID, 8'hFE, 32'h0, 32'h0, 1'b0, 0, 0});
    probe_rows.push_back('{2'd3, MODE_BLEND, 8'hE1, 32'h0, WHITE, 1'b0, 0, 0});
    probe_rows.push_back('{2'd2, MODE_BLEND, 8'h1E, WHITE, 32'h0, 1'b0, 0, 0});
    probe_rows.push_back('{2'd1, MODE_SOLID, 8'h77, 32'h55555555, 32'hAAAAAAAA, 1'b0, 0, 0});
    probe_rows.push_back('{2'd3, MODE_BLEND, 8'h88, 32'hAAAAAAAA, 32'h55555555, 1'b0, 0, 0});

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur_sel = 2'd0;
    cur_mode = MODE_SOLID;
    for (int i = 0; i < probe_rows.size(); i++) begin
      row = probe_rows[i];
      if (i == RESET_ROWS) begin
        drain_results();
        write_reg(REG_COLOR_ZERO, WHITE);
        write_reg(REG_COLOR_ONE, 32'h0);
        write_reg(REG_COLOR_TWO, 32'h12345678);
        write_reg(REG_COLOR_THREE, 32'h80FF00FF);
      end
      if (row.sel != cur_sel || row.mode != cur_mode) begin
        drain_results();
        // upper bits beyond the register width are dropped
        write_reg(REG_COLOR_SELECT, {30'h3FFFFFFF, row.sel});
        write_reg(REG_BLEND_MODE, {31'h7FFFFFFF, row.mode});
        cur_sel = row.sel;
        cur_mode = row.mode;
      end
      want.lo = row.want_lo;
      want.hi = row.want_hi;
      send_request(row.cov, row.dlo, row.dhi, row.known, want);
    end

    for (int blk = 0; blk < BLOCK_COUNT; blk++) begin
      drain_results();
      for (int r = 0; r < 4; r++) begin
        case ($urandom_range(3))
          0: write_reg(cfg_idx_t'(r), 32'h0);
          1: write_reg(cfg_idx_t'(r), WHITE);
          default: write_reg(cfg_idx_t'(r), $urandom);
        endcase
      end
      write_reg(REG_COLOR_SELECT, (blk < 4) ? 32'(blk) : $urandom);
      write_reg(REG_BLEND_MODE, (blk < 2) ? 32'(blk) : $urandom);
      // writes to unmapped indexes must leave every register alone
      write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
      case (blk % 4)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 69;
          recv_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct = 69;
        end
        default: begin
          sender_idle_pct = 7;
          recv_stall_pct = 7;
        end
      endcase
      for (int k = 0; k < BLOCK_ITEMS; k++) begin
        cov = 8'($urandom);
        dlo = $urandom;
        dhi = $urandom;
        case ($urandom_range(7))
          0: cov[3:0] = $urandom_range(1) ? 4'h0 : 4'hF;
          1: cov[7:4] = $urandom_range(1) ? 4'h0 : 4'hF;
          2: begin
            dlo = $urandom_range(1) ? 32'h0 : WHITE;
            dhi = $urandom_range(1) ? 32'h0 : WHITE;
          end
          default: ;
        endcase
        want = '0;
        send_request(cov, dlo, dhi, 1'b0, want);
      end
    end

    sender_idle_pct = 0;
    recv_stall_pct = 0;
    drain_results();
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: glyph_coverage_pixel_blender.f
+incdir+src
src/gcpb_pkg.sv
src/gcpb_lane.sv
src/gcpb_out_stage.sv
src/glyph_coverage_pixel_blender.sv
bench/glyph_coverage_pixel_blender_tb.sv
